// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checks a property that is evaluated during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ===== hdl/podo_pkg.sv =====
`default_nettype none
package podo_pkg;
  localparam int CordicStagesDef = 16;
  localparam int PositionWidthDef = 32;
  localparam int AngTableLen = 30;
  localparam int CordicW = 34;
  localparam logic signed [CordicW-1:0] CordicX0 = 34'sd652032874;
  localparam logic [31:0] RadToBam = 32'd2734261102;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CORD1, ST_MUL_XC, ST_MUL_YS, ST_MUL_XS, ST_MUL_YC,
    ST_DT_X, ST_DT_Y, ST_MUL_R, ST_MUL_HI, ST_MUL_LO, ST_HEAD,
    ST_CORD2, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [31:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic done;
    logic signed [CordicW-1:0] cs;
    logic signed [CordicW-1:0] sn;
  } cordic_rsp_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0: v = 32'd536870912;
      5'd1: v = 32'd316933406;
      5'd2: v = 32'd167458907;
      5'd3: v = 32'd85004756;
      5'd4: v = 32'd42667331;
      5'd5: v = 32'd21354465;
      5'd6: v = 32'd10679838;
      5'd7: v = 32'd5340245;
      5'd8: v = 32'd2670163;
      5'd9: v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== hdl/podo_cordic.sv =====
`default_nettype none
module podo_cordic #(
  parameter int CORDIC_STAGES = podo_pkg::CordicStagesDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire podo_pkg::cordic_req_t req,
  output podo_pkg::cordic_rsp_t   rsp
);
  import podo_pkg::*;
  `include "assert_macros.svh"

  localparam int IterW = $clog2(CORDIC_STAGES + 1);

  logic busy_r, busy_nxt;
  logic flip_r, flip_nxt;
  logic done_r, done_nxt;
  logic [IterW-1:0] iter_r, iter_nxt;
  logic signed [CordicW-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [32:0] z_r, z_nxt;
  logic [31:0] ang_adj;
  logic [4:0] tidx;
  logic signed [32:0] tval;

  assign tidx = 5'(iter_r);
  assign tval = $signed({1'b0, atan_bam(tidx)});

  always_comb begin
    busy_nxt = busy_r;
    flip_nxt = flip_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    ang_adj = req.angle;
    if (req.start) begin
      flip_nxt = (req.angle[31:30] == 2'b01) || (req.angle[31:30] == 2'b10);
      if (flip_nxt) begin
        ang_adj = req.angle + 32'h8000_0000;
      end
      x_nxt = CordicX0;
      y_nxt = '0;
      z_nxt = $signed({ang_adj[31], ang_adj});
      iter_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_nxt = x_r - (y_r >>> iter_r);
        y_nxt = y_r + (x_r >>> iter_r);
        z_nxt = z_r - tval;
      end else begin
        x_nxt = x_r + (y_r >>> iter_r);
        y_nxt = y_r - (x_r >>> iter_r);
        z_nxt = z_r + tval;
      end
      iter_nxt = iter_r + 1'b1;
      if (iter_r == IterW'(CORDIC_STAGES - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    flip_r <= flip_nxt;
    iter_r <= iter_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  always_comb begin
    rsp.done = done_r;
    rsp.cs = flip_r ? -x_r : x_r;
    rsp.sn = flip_r ? -y_r : y_r;
  end

  `ASSERT_IMPL(a_done_pulse, clk, rst_n, done_r |=> !done_r, "cordic done longer than a cycle")
  `ASSERT_IMPL(a_done_busy, clk, rst_n, done_r |-> !busy_r, "cordic done while busy")
  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !busy_r && !done_r, "cordic active after reset")
endmodule
`default_nettype wire

// ===== hdl/planar_odometry_integrator.sv =====
// One input beat is worked on at a time: in_ready is low during the work, so no new beat is
// accepted before the result of the last one has been loaded into the output registers.
// The work uses the shared iterative CORDIC (run twice) and one multiplier.
// A result that waits at the output holds the block in its last step until it is taken.
// Reset (rst_n low, synchronous) clears position and heading to zero and empties the output.
`default_nettype none
module planar_odometry_integrator #(
  parameter int CORDIC_STAGES = podo_pkg::CordicStagesDef,
  parameter int POSITION_WIDTH = podo_pkg::PositionWidthDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [23:0] in_vel_x,
  input  wire logic signed [23:0] in_vel_y,
  input  wire logic signed [23:0] in_yaw_rate,
  input  wire logic [23:0]        in_time_step,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_pos_x,
  output logic signed [31:0]      out_pos_y,
  output logic [31:0]             out_heading,
  output logic signed [15:0]      out_quat_z,
  output logic signed [15:0]      out_quat_w
);
  import podo_pkg::*;
  `include "assert_macros.svh"

  localparam int PW = POSITION_WIDTH;

  state_t state_r, state_nxt;
  cordic_req_t creq;
  cordic_rsp_t crsp;

  logic signed [23:0] vx_r, vy_r, wr_r;
  logic [23:0] dt_r;
  logic signed [CordicW-1:0] c_r, s_r;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [63:0] prod;
  logic signed [33:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [31:0] rv;
  logic signed [31:0] rvx_r;
  logic signed [PW-1:0] pose_x_r, pose_x_nxt, pose_y_r, pose_y_nxt;
  logic [31:0] yaw_r, yaw_nxt;
  logic neg_r, neg_nxt;
  logic [47:0] mag_r, mag_nxt;
  logic [63:0] u_acc_r, u_acc_nxt;
  logic [31:0] u;
  logic out_valid_r, out_valid_nxt;
  logic out_load;
  logic signed [15:0] qz_r, qz_nxt, qw_r, qw_nxt;
  logic signed [31:0] out_pos_x_r, out_pos_y_r;
  logic [31:0] out_heading_r;
  logic signed [15:0] out_quat_z_r, out_quat_w_r;

  podo_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp)
  );

  function automatic logic signed [15:0] to_q14(input logic signed [CordicW-1:0] v);
    logic signed [CordicW-1:0] r;
    r = (v + CordicW'(32768)) >>> 16;
    if (r > CordicW'(16384)) r = CordicW'(16384);
    if (r < -CordicW'(16384)) r = -CordicW'(16384);
    return r[15:0];
  endfunction

  // Shared multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL_XC: begin mul_a = 34'(vx_r); mul_b = c_r; end
      ST_MUL_YS: begin mul_a = 34'(vy_r); mul_b = s_r; end
      ST_MUL_XS: begin mul_a = 34'(vx_r); mul_b = s_r; end
      ST_MUL_YC: begin mul_a = 34'(vy_r); mul_b = c_r; end
      ST_DT_X: begin mul_a = 34'(rvx_r); mul_b = $signed({10'd0, dt_r}); end
      ST_DT_Y: begin mul_a = 34'(rv); mul_b = $signed({10'd0, dt_r}); end
      ST_MUL_R: begin mul_a = 34'(wr_r); mul_b = $signed({10'd0, dt_r}); end
      ST_MUL_HI: begin
        mul_a = $signed({10'd0, mag_r[47:24]}); mul_b = $signed({2'd0, RadToBam});
      end
      ST_MUL_LO: begin
        mul_a = $signed({10'd0, mag_r[23:0]}); mul_b = $signed({2'd0, RadToBam});
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = 64'(mul_a * mul_b);
  assign rv = 32'((acc_r + 64'sd536870912) >>> 30);
  assign u = 32'((u_acc_r + 64'd8192) >> 14);
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid && in_ready) state_nxt = ST_CORD1;
      ST_CORD1:  if (crsp.done) state_nxt = ST_MUL_XC;
      ST_MUL_XC: state_nxt = ST_MUL_YS;
      ST_MUL_YS: state_nxt = ST_MUL_XS;
      ST_MUL_XS: state_nxt = ST_DT_X;
      ST_DT_X:   state_nxt = ST_MUL_YC;
      ST_MUL_YC: state_nxt = ST_DT_Y;
      ST_DT_Y:   state_nxt = ST_MUL_R;
      ST_MUL_R:  state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_MUL_LO;
      ST_MUL_LO: state_nxt = ST_HEAD;
      ST_HEAD:   state_nxt = ST_CORD2;
      ST_CORD2:  if (crsp.done) state_nxt = ST_OUT;
      ST_OUT:    if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    creq.start = 1'b0;
    creq.angle = yaw_r;
    acc_nxt = acc_r;
    pose_x_nxt = pose_x_r;
    pose_y_nxt = pose_y_r;
    yaw_nxt = yaw_r;
    neg_nxt = neg_r;
    mag_nxt = mag_r;
    u_acc_nxt = u_acc_r;
    out_valid_nxt = out_valid_r;
    qz_nxt = qz_r;
    qw_nxt = qw_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: if (in_valid && in_ready) creq.start = 1'b1;
      ST_MUL_XC: acc_nxt = prod;
      ST_MUL_YS: acc_nxt = acc_r - prod;
      ST_MUL_XS: acc_nxt = prod;
      ST_DT_X: begin
        // The x rotation sum was parked in rvx_r before acc was reused.
        pose_x_nxt = pose_x_r + PW'((prod + 64'sd524288) >>> 20);
      end
      ST_MUL_YC: acc_nxt = acc_r + prod;
      ST_DT_Y: pose_y_nxt = pose_y_r + PW'((prod + 64'sd524288) >>> 20);
      ST_MUL_R: begin
        neg_nxt = prod < 0;
        mag_nxt = 48'(prod < 0 ? -prod : prod);
      end
      ST_MUL_HI: u_acc_nxt = 64'(prod);
      ST_MUL_LO: u_acc_nxt = u_acc_r + 64'(prod[63:24]);
      ST_HEAD: begin
        yaw_nxt = neg_r ? yaw_r - u : yaw_r + u;
      end
      ST_CORD2: begin
        if (crsp.done) begin
          qw_nxt = to_q14(crsp.cs);
          qz_nxt = to_q14(crsp.sn);
        end
      end
      ST_OUT: if (out_load) out_valid_nxt = 1'b1;
      default: ;
    endcase
    if (state_r == ST_HEAD) begin
      creq.start = 1'b1;
      creq.angle = {1'b0, yaw_nxt[31:1]};
    end
  end

  // The x rotation sum is parked before the y products reuse acc.
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL_XS) rvx_r <= rv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      pose_x_r <= '0;
      pose_y_r <= '0;
      yaw_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      yaw_r <= yaw_nxt;
      pose_x_r <= pose_x_nxt;
      pose_y_r <= pose_y_nxt;
    end
    if (in_valid && in_ready) begin
      vx_r <= in_vel_x;
      vy_r <= in_vel_y;
      wr_r <= in_yaw_rate;
      dt_r <= in_time_step;
    end
    if (state_r == ST_CORD1 && crsp.done) begin
      c_r <= crsp.cs;
      s_r <= crsp.sn;
    end
    if (out_load) begin
      out_pos_x_r <= 32'(pose_x_r);
      out_pos_y_r <= 32'(pose_y_r);
      out_heading_r <= yaw_r;
      out_quat_z_r <= qz_r;
      out_quat_w_r <= qw_r;
    end
    acc_r <= acc_nxt;
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    u_acc_r <= u_acc_nxt;
    qz_r <= qz_nxt;
    qw_r <= qw_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = out_pos_x_r;
  assign out_pos_y = out_pos_y_r;
  assign out_heading = out_heading_r;
  assign out_quat_z = out_quat_z_r;
  assign out_quat_w = out_quat_w_r;

  `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, (state_r != ST_IDLE) |-> !in_ready, "ready while busy")
  `ASSERT_IMPL(a_out_after_work, clk, rst_n, $rose(out_valid_r) |-> $past(state_r) == ST_OUT, "result without work")
  `ASSERT_IMPL(a_pose_stable_idle, clk, rst_n, (state_r == ST_IDLE) && $past(state_r) == ST_IDLE |-> $stable(yaw_r), "heading moved while idle")
endmodule
`default_nettype wire
